// ===== design/pfd_pkg.sv =====
// Shared types and codes for the packet FIFO with duplicate filter.
// Used by pfd_ctrl, pfd_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package pfd_pkg;

  localparam int DEF_MAX_PACKETS = 64;

  localparam int CAP_W = 7;
  localparam int CNT_OUT_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_FWD = 2'd1;
  localparam logic [1:0] OP_CNT = 2'd2;

  typedef struct packed {
    logic capture;  // take the input transaction
    logic issue;    // read the entry at the scan pointer
    logic commit;   // update queue state and load the result register
  } pfd_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       occ_zero;
    logic       scan_last;
    logic       out_free;
  } pfd_status_t;

endpackage

// ===== design/packet_fifo_dedup_range_count.sv =====
// Top level of the bounded packet FIFO with duplicate filter and window count.
// Depends on pfd_pkg, pfd_ctrl and pfd_datapath.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   input    | in_valid / in_ready  | op, source, destination, timestamp,
//            |                      | start_time, end_time
//   result   | out_valid/out_ready  | accepted, packet_valid, out_source,
//            |                      | out_destination, out_timestamp, match_count
//   config   | cfg_write_en         | cfg_write_data (capacity_limit)
//
// Add and count read the store once per queued packet through the single
// registered read port; forward reads only the head entry, and an unknown
// op or an empty queue reads nothing.
// One transaction is in flight at a time; a new one is taken while the
// previous result still sits in the output register.
// A stalled result holds the commit until out_ready; rst is synchronous
// and empties the queue without touching the store.
`timescale 1ns / 1ps

module packet_fifo_dedup_range_count #(
  parameter int MAX_PACKETS = pfd_pkg::DEF_MAX_PACKETS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [pfd_pkg::CAP_W-1:0]     cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [15:0]                   source,
  input  logic [15:0]                   destination,
  input  logic [31:0]                   timestamp,
  input  logic [31:0]                   start_time,
  input  logic [31:0]                   end_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic                          packet_valid,
  output logic [15:0]                   out_source,
  output logic [15:0]                   out_destination,
  output logic [31:0]                   out_timestamp,
  output logic [pfd_pkg::CNT_OUT_W-1:0] match_count
);
  import pfd_pkg::*;

  pfd_cmd_t    cmd;
  pfd_status_t status;

  pfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pfd_datapath #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .op              (op),
    .source          (source),
    .destination     (destination),
    .timestamp       (timestamp),
    .start_time      (start_time),
    .end_time        (end_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .packet_valid    (packet_valid),
    .out_source      (out_source),
    .out_destination (out_destination),
    .out_timestamp   (out_timestamp),
    .match_count     (match_count),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

// ===== design/pfd_ctrl.sv =====
// Sequencer for the packet FIFO: walks the stored entries one per cycle for add and count.
// Depends on pfd_pkg for the command/status structs and op codes.
`timescale 1ns / 1ps

module pfd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pfd_pkg::pfd_status_t status,
  output pfd_pkg::pfd_cmd_t    cmd
);
  import pfd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       scan_op;

  assign in_ready = (state == S_IDLE);
  assign scan_op  = (status.op == OP_ADD) || (status.op == OP_CNT);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.op == OP_FWD && !status.occ_zero) begin
          cmd.issue  = 1'b1;
          state_next = S_DRAIN;
        end else if (scan_op && !status.occ_zero) begin
          cmd.issue = 1'b1;
          if (status.scan_last) begin
            state_next = S_DRAIN;
          end
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DRAIN: begin
        // last read data is compared this cycle
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_commit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && !status.out_free) |=> (state == S_COMMIT))
    else $error("commit left before result register was free");

  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_SCAN))
    else $error("capture did not start a scan");

  a_issue_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (state == S_SCAN))
    else $error("store read issued outside a scan");

endmodule

// ===== design/pfd_datapath.sv =====
// Packet store, queue pointers, scan compare and result register.
// Depends on pfd_pkg; driven by pfd_ctrl through pfd_cmd_t.
`timescale 1ns / 1ps

module pfd_datapath #(
  parameter int MAX_PACKETS = pfd_pkg::DEF_MAX_PACKETS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [pfd_pkg::CAP_W-1:0]     cfg_write_data,
  input  logic [1:0]                    op,
  input  logic [15:0]                   source,
  input  logic [15:0]                   destination,
  input  logic [31:0]                   timestamp,
  input  logic [31:0]                   start_time,
  input  logic [31:0]                   end_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic                          packet_valid,
  output logic [15:0]                   out_source,
  output logic [15:0]                   out_destination,
  output logic [31:0]                   out_timestamp,
  output logic [pfd_pkg::CNT_OUT_W-1:0] match_count,
  input  pfd_pkg::pfd_cmd_t             cmd,
  output pfd_pkg::pfd_status_t          status
);
  import pfd_pkg::*;

  localparam int AW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int CW = $clog2(MAX_PACKETS + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam int SW = CW + 1;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(MAX_PACKETS - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [CAP_W-1:0] capacity_limit;

  logic [1:0]  op_q;
  logic [15:0] src_q;
  logic [15:0] dst_q;
  logic [31:0] ts_q;
  logic [31:0] lo_q;
  logic [31:0] hi_q;

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [CW-1:0] occ;
  logic [AW-1:0] scan_ptr;
  logic [CW-1:0] idx;
  logic          rd_pending;
  logic [63:0]   rdata;
  logic          dup;
  logic [CW-1:0] cnt;

  logic [63:0] mem [MAX_PACKETS];

  logic [LW-1:0] lim_ext;
  logic [LW-1:0] lim_eff;
  logic          at_limit;
  logic          add_ok;
  logic          fwd_ok;
  logic          hit_all;
  logic          hit_win;

  assign lim_ext  = LW'(capacity_limit);
  assign lim_eff  = (capacity_limit == '0) ? LW'(1) :
                    (lim_ext > LW'(MAX_PACKETS)) ? LW'(MAX_PACKETS) : lim_ext;
  assign at_limit = (LW'(occ) >= lim_eff);
  assign add_ok   = (op_q == OP_ADD) && !dup;
  assign fwd_ok   = (op_q == OP_FWD) && (occ != '0);

  // entry layout: {source, destination, timestamp}
  assign hit_all = (rdata[63:48] == src_q) && (rdata[47:32] == dst_q) &&
                   (rdata[31:0] == ts_q);
  assign hit_win = (rdata[47:32] == dst_q) && (rdata[31:0] >= lo_q) &&
                   (rdata[31:0] <= hi_q);

  assign status.op        = op_q;
  assign status.occ_zero  = (occ == '0);
  assign status.scan_last = (CW'(idx + CW'(1)) == occ);
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.commit && add_ok) begin
      mem[tail] <= {src_q, dst_q, ts_q};
    end
    if (cmd.issue) begin
      rdata <= mem[scan_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op;
      src_q <= source;
      dst_q <= destination;
      ts_q <= timestamp;
      lo_q <= start_time;
      hi_q <= end_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
      head <= '0;
      tail <= '0;
      occ <= '0;
      scan_ptr <= '0;
      idx <= '0;
      rd_pending <= 1'b0;
      dup <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_write_en) begin
        capacity_limit <= cfg_write_data;
      end
      rd_pending <= cmd.issue;
      if (cmd.capture) begin
        scan_ptr <= head;
        idx <= '0;
        dup <= 1'b0;
        cnt <= '0;
      end else begin
        if (cmd.issue) begin
          scan_ptr <= wrap_inc(scan_ptr);
          idx <= idx + CW'(1);
        end
        if (rd_pending) begin
          if (hit_all) begin
            dup <= 1'b1;
          end
          if (hit_win) begin
            cnt <= cnt + CW'(1);
          end
        end
      end
      if (cmd.commit) begin
        if (add_ok) begin
          tail <= wrap_inc(tail);
          if (at_limit) begin
            head <= wrap_inc(head);
          end else begin
            occ <= occ + CW'(1);
          end
        end else if (fwd_ok) begin
          head <= wrap_inc(head);
          occ <= occ - CW'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      accepted <= add_ok;
      packet_valid <= fwd_ok;
      out_source <= fwd_ok ? rdata[63:48] : '0;
      out_destination <= fwd_ok ? rdata[47:32] : '0;
      out_timestamp <= fwd_ok ? rdata[31:0] : '0;
      match_count <= (op_q == OP_CNT) ? CNT_OUT_W'(cnt) : '0;
    end
  end

  logic [SW-1:0] pos_sum;
  logic [SW-1:0] pos_wrap;
  assign pos_sum  = SW'(head) + SW'(occ);
  assign pos_wrap = (pos_sum >= SW'(MAX_PACKETS)) ? pos_sum - SW'(MAX_PACKETS) : pos_sum;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    SW'(occ) <= SW'(MAX_PACKETS))
    else $error("occupancy above store depth");

  a_tail_track: assert property (@(posedge clk) disable iff (rst)
    tail == AW'(pos_wrap))
    else $error("tail pointer out of step with head and occupancy");

  a_evict_keeps_occ: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && add_ok && at_limit) |=> (occ == $past(occ)))
    else $error("eviction on add changed occupancy");

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten before taken");

endmodule

// ===== bench/packet_fifo_dedup_range_count_test.sv =====
// Self-checking bench for packet_fifo_dedup_range_count: a directed part, then random phases.
// The phases cover the capacity limit, adds, forwards, window counts and the unused op code.
// Depends on pfd_pkg and the design sources; reads no files.
`timescale 1ns / 1ps

module packet_fifo_dedup_range_count_test;
  import pfd_pkg::*;

  localparam int DEPTH = DEF_MAX_PACKETS;
  localparam int CYCLE_LIMIT = 500000;
  localparam int CALM_TAIL = 50;      // final requests run without idling on either side
  localparam int SETTLE_CYCLES = 80;  // longer than a full-queue scan
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef enum logic [1:0] {REQ_ITEM, REQ_LIMIT, REQ_DRAIN} req_kind_t;

  typedef struct packed {
    req_kind_t        kind;
    logic [CAP_W-1:0] limit;
    logic [1:0]       op;
    logic [15:0]      source;
    logic [15:0]      destination;
    logic [31:0]      timestamp;
    logic [31:0]      start_time;
    logic [31:0]      end_time;
  } bench_req_t;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
  } packet_t;

  typedef struct packed {
    logic                 accepted;
    logic                 packet_valid;
    logic [15:0]          src;
    logic [15:0]          dst;
    logic [31:0]          ts;
    logic [CNT_OUT_W-1:0] count;
  } fifo_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CAP_W-1:0]     cfg_write_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           op = OP_ADD;
  logic [15:0]          source = '0;
  logic [15:0]          destination = '0;
  logic [31:0]          timestamp = '0;
  logic [31:0]          start_time = '0;
  logic [31:0]          end_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 accepted;
  logic                 packet_valid;
  logic [15:0]          out_source;
  logic [15:0]          out_destination;
  logic [31:0]          out_timestamp;
  logic [CNT_OUT_W-1:0] match_count;

  packet_fifo_dedup_range_count DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .source          (source),
    .destination     (destination),
    .timestamp       (timestamp),
    .start_time      (start_time),
    .end_time        (end_time),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .packet_valid    (packet_valid),
    .out_source      (out_source),
    .out_destination (out_destination),
    .out_timestamp   (out_timestamp),
    .match_count     (match_count)
  );

  always #6 clk = ~clk;

  // Predicted queue contents and limit
  packet_t          fifo_mem [DEPTH];
  int unsigned      fifo_head;
  int unsigned      fifo_occ;
  logic [CAP_W-1:0] limit_reg;

  bench_req_t   request_queue[$];
  fifo_result_t due_results[$];
  packet_t      recent_adds[$];
  logic [31:0]  ts_now;
  bit           in_took = 1'b0;
  int           errors = 0;
  int           cycle_count = 0;

  function automatic fifo_result_t model_fifo_op(input logic [1:0] req_op,
                                                 input packet_t pkt,
                                                 input logic [31:0] lo,
                                                 input logic [31:0] hi);
    fifo_result_t r;
    int unsigned  lim;
    int unsigned  cnt;
    int unsigned  i;
    packet_t      p;
    bit           dup;
    r = '0;
    dup = 1'b0;
    cnt = 0;
    lim = (limit_reg == 0) ? 1 : ((limit_reg > DEPTH) ? DEPTH : limit_reg);
    case (req_op)
      OP_ADD: begin
        for (i = 0; i < fifo_occ; i++)
          if (fifo_mem[(fifo_head + i) % DEPTH] == pkt) dup = 1'b1;
        if (!dup) begin
          if (fifo_occ >= lim) begin
            fifo_head = (fifo_head + 1) % DEPTH;
            fifo_occ--;
          end
          fifo_mem[(fifo_head + fifo_occ) % DEPTH] = pkt;
          fifo_occ++;
          r.accepted = 1'b1;
        end
      end
      OP_FWD: begin
        if (fifo_occ != 0) begin
          p = fifo_mem[fifo_head];
          r.packet_valid = 1'b1;
          r.src = p.src;
          r.dst = p.dst;
          r.ts = p.ts;
          fifo_head = (fifo_head + 1) % DEPTH;
          fifo_occ--;
        end
      end
      OP_CNT: begin
        for (i = 0; i < fifo_occ; i++) begin
          p = fifo_mem[(fifo_head + i) % DEPTH];
          if (p.dst == pkt.dst && p.ts >= lo && p.ts <= hi) cnt++;
        end
        r.count = cnt[CNT_OUT_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic push_packet(input logic [1:0] req_op, input logic [15:0] src,
                             input logic [15:0] dst, input logic [31:0] ts,
                             input logic [31:0] lo, input logic [31:0] hi);
    bench_req_t r;
    r = '{REQ_ITEM, '0, req_op, src, dst, ts, lo, hi};
    request_queue = {request_queue, r};
  endtask

  task automatic push_limit(input logic [CAP_W-1:0] lim);
    bench_req_t r;
    r = '0;
    r.kind = REQ_LIMIT;
    r.limit = lim;
    request_queue = {request_queue, r};
  endtask

  task automatic push_drain();
    bench_req_t r;
    r = '0;
    r.kind = REQ_DRAIN;
    request_queue = {request_queue, r};
  endtask

  // One random transaction; add_pct sets how hard the queue is pushed towards full
  task automatic add_random_item(input int unsigned add_pct);
    packet_t     p;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [15:0] dst;
    int unsigned pick;
    int unsigned w;
    pick = $urandom_range(0, 99);
    lo = $urandom;
    hi = $urandom;
    if (pick < add_pct) begin
      if (recent_adds.size() > 0 && $urandom_range(0, 4) == 0) begin
        // re-offer a recent packet to provoke the duplicate filter
        p = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
      end else begin
        p.src = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        p.dst = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        ts_now += $urandom_range(0, 2);
        p.ts = ($urandom_range(0, 19) == 0) ? 32'($urandom) : ts_now;
        recent_adds = {recent_adds, p};
        if (recent_adds.size() > 16) recent_adds.delete(0);
      end
      push_packet(OP_ADD, p.src, p.dst, p.ts, lo, hi);
    end else if (pick < add_pct + (100 - add_pct) * 2 / 5) begin
      push_packet(OP_FWD, 16'($urandom), 16'($urandom), $urandom, lo, hi);
    end else if (pick < 96) begin
      if (recent_adds.size() > 0 && $urandom_range(0, 1) == 0)
        dst = recent_adds[$urandom_range(0, recent_adds.size() - 1)].dst;
      else
        dst = 16'($urandom_range(0, 3));
      w = $urandom_range(0, 9);
      if (w < 7) begin
        lo = ts_now - $urandom_range(0, 40);
        hi = lo + $urandom_range(0, 40);
      end else if (w == 7) begin
        lo = '0;
        hi = '1;
      end else if (w == 8) begin
        // inverted window
        lo = ts_now;
        hi = ts_now - $urandom_range(1, 40);
      end
      push_packet(OP_CNT, 16'($urandom), dst, $urandom, lo, hi);
    end else begin
      push_packet(OP_NONE, 16'($urandom), 16'($urandom), $urandom, lo, hi);
    end
  endtask

  // Sender side
  always @(negedge clk) begin : drive_requests
    logic        next_valid;
    logic        next_wr;
    bench_req_t  head_req;
    int unsigned gap_left;
    next_valid = in_valid;
    next_wr = 1'b0;
    if (!rst) begin
      if (in_valid && in_took) begin
        next_valid = 1'b0;
        in_took = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0) begin
          head_req = request_queue[0];
          case (head_req.kind)
            REQ_LIMIT: begin
              if (due_results.size() == 0) begin
                next_wr = 1'b1;
                cfg_write_data <= head_req.limit;
                request_queue.delete(0);
              end
            end
            REQ_DRAIN: begin
              if (due_results.size() == 0) request_queue.delete(0);
            end
            default: begin
              if (request_queue.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 14);
              end else begin
                op          <= head_req.op;
                source      <= head_req.source;
                destination <= head_req.destination;
                timestamp   <= head_req.timestamp;
                start_time  <= head_req.start_time;
                end_time    <= head_req.end_time;
                next_valid = 1'b1;
                request_queue.delete(0);
              end
            end
          endcase
        end
      end
    end
    in_valid <= next_valid;
    cfg_write_en <= next_wr;
  end

  // Receiver side back-pressure
  always @(negedge clk) begin : drive_ready
    int unsigned stall_left;
    logic        rdy;
    rdy = 1'b1;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (request_queue.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      rdy = 1'b0;
    end
    out_ready <= rdy;
  end

  // Watches both channels and the register port; results are checked before the
  // transaction taken at the same edge is predicted
  always @(posedge clk) begin : watch_ports
    fifo_result_t want;
    packet_t      pkt;
    if (rst) begin
      fifo_head = 0;
      fifo_occ = 0;
      limit_reg = CAP_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: result with nothing expected, expected none, actual acc %0b pv %0b cnt %0d",
                   $time, accepted, packet_valid, match_count);
          errors++;
        end else begin
          want = due_results[0];
          due_results.delete(0);
          compare_field("accepted", 32'(want.accepted), 32'(accepted));
          compare_field("packet_valid", 32'(want.packet_valid), 32'(packet_valid));
          compare_field("out_source", 32'(want.src), 32'(out_source));
          compare_field("out_destination", 32'(want.dst), 32'(out_destination));
          compare_field("out_timestamp", want.ts, out_timestamp);
          compare_field("match_count", 32'(want.count), 32'(match_count));
        end
      end
      if (cfg_write_en) limit_reg = cfg_write_data;
      if (in_valid && in_ready) begin
        pkt = '{source, destination, timestamp};
        want = model_fifo_op(op, pkt, start_time, end_time);
        due_results = {due_results, want};
        in_took = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CAP_W-1:0] phase_limit [8];
    int unsigned      phase_add_pct [8];
    int               ph;
    int               k;

    // Directed: empty queue, extremes, duplicates and the limit corner cases
    push_packet(OP_FWD, '0, '0, '0, '0, '0);
    push_packet(OP_CNT, '0, '0, '0, '0, '1);
    push_packet(OP_NONE, '1, '1, '1, '1, '1);
    push_packet(OP_ADD, '0, '0, '0, '0, '0);
    push_packet(OP_ADD, '1, '1, '1, '0, '0);
    push_packet(OP_ADD, '1, '1, '1, '1, '1);
    push_packet(OP_CNT, '0, '1, '0, '0, '1);
    push_packet(OP_CNT, '0, '1, '0, '1, '1);
    push_packet(OP_CNT, '0, '0, '0, 32'd5, 32'd4);
    push_packet(OP_CNT, '0, '0, '0, '0, '0);
    push_packet(OP_FWD, '0, '0, '0, '0, '0);
    push_packet(OP_FWD, '0, '0, '0, '0, '0);
    push_packet(OP_FWD, '1, '1, '1, '1, '1);
    push_limit(7'd1);
    push_packet(OP_ADD, 16'd1, 16'd2, 32'd3, '0, '0);
    push_packet(OP_ADD, 16'd4, 16'd5, 32'd6, '0, '0);
    push_packet(OP_ADD, 16'd4, 16'd5, 32'd6, '0, '0);  // duplicate on a full queue
    push_packet(OP_CNT, '0, 16'd5, '0, '0, '1);
    push_packet(OP_FWD, '0, '0, '0, '0, '0);
    push_limit(7'd0);                                  // behaves as one
    push_packet(OP_ADD, 16'd7, 16'd8, 32'd9, '0, '0);
    push_packet(OP_ADD, 16'd7, 16'd8, 32'd10, '0, '0);
    push_packet(OP_FWD, '0, '0, '0, '0, '0);
    push_limit('1);                                    // above the store depth
    for (k = 0; k < 6; k++) push_packet(OP_ADD, 16'(k + 1), 16'd3, 32'(100 + k), '0, '0);
    push_limit(7'd3);                                  // now below occupancy
    push_packet(OP_ADD, 16'd9, 16'd3, 32'd106, '0, '0);
    push_packet(OP_CNT, '0, 16'd3, '0, 32'd100, 32'd200);
    push_packet(OP_ADD, 16'd9, 16'd3, 32'd106, '0, '0);

    // Random phases; the queue carries over from one limit to the next
    phase_limit = '{7'd127, 7'd1, 7'd5, 7'd0, 7'd40, 7'($urandom_range(1, 127)), 7'd64, 7'd2};
    phase_add_pct = '{85, 50, 50, 50, 60, 55, 80, 45};
    for (ph = 0; ph < 8; ph++) begin
      push_limit(phase_limit[ph]);
      ts_now = (ph == 6) ? 32'hFFFF_FF80 : 32'($urandom);
      for (k = 0; k < 72; k++) begin
        add_random_item(phase_add_pct[ph]);
        if (ph == 4 && k == 36) push_drain();
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    do @(posedge clk);
    while (request_queue.size() != 0 || in_valid || due_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pfd_pkg.sv
design/pfd_ctrl.sv
design/pfd_datapath.sv
design/packet_fifo_dedup_range_count.sv
bench/packet_fifo_dedup_range_count_test.sv
